>>> rtl/core/preemptive_priority_scheduler_aging_core_assert.svh
// assertion macros for the scheduler core
// expects clk and rst in the scope of use
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_AGING_CORE_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_AGING_CORE_ASSERT_SVH
`define PPSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define PPSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/core/ppsa_pkg.sv
// shared types and constants of the scheduler core
// no dependencies
package ppsa_pkg;
  localparam int MAX_ENTRIES_DEF = 16;
  localparam logic [7:0] AGING_RESET = 8'd1;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;
  localparam logic signed [15:0] PRIO_MIN = 16'sh8000;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] prio;
    logic [15:0] arr;
    logic [15:0] burst;
    logic [15:0] rem;
    logic        started;
    logic [15:0] resp;
  } entry_t;

  typedef struct packed {
    logic load;
    logic age;
    logic start;
    logic dec;
  } cell_ctl_t;
endpackage

>>> rtl/core/ppsa_cell.sv
// one process table entry with load, aging, start and run updates
// depends on ppsa_pkg
module ppsa_cell (
  input  logic               clk,
  input  logic               rst,
  input  ppsa_pkg::cell_ctl_t ctl,
  input  logic [7:0]         ld_id,
  input  logic [15:0]        ld_prio,
  input  logic [15:0]        ld_arr,
  input  logic [15:0]        ld_burst,
  input  logic [15:0]        now,
  input  logic [7:0]         step,
  input  logic [15:0]        start_resp,
  output ppsa_pkg::entry_t   ent
);
  logic [16:0] aged;

  assign aged = {ent.prio[15], ent.prio} - {9'b0, step};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ent.id <= ld_id;
      ent.prio <= ld_prio;
      ent.arr <= ld_arr;
      ent.burst <= (ld_burst == 16'd0) ? 16'd1 : ld_burst;
      ent.rem <= (ld_burst == 16'd0) ? 16'd1 : ld_burst;
      ent.resp <= 16'd0;
    end else begin
      if (ctl.age && ent.rem != 16'd0 && ent.arr <= now && !ent.started) begin
        ent.prio <= (aged[16] != aged[15]) ? ppsa_pkg::PRIO_MIN : aged[15:0];
      end
      if (ctl.start && !ent.started) begin
        ent.resp <= start_resp;
      end
      if (ctl.dec) begin
        ent.rem <= ent.rem - 16'd1;
      end
    end
    if (rst) begin
      ent.started <= 1'b0;
    end else if (ctl.load) begin
      ent.started <= 1'b0;
    end else if (ctl.start) begin
      ent.started <= 1'b1;
    end
  end
endmodule

>>> rtl/core/preemptive_priority_scheduler_aging_core.sv
// scheduler core: row of entry cells and the tick sequencer
// depends on ppsa_pkg, ppsa_cell and the assertion header
// a tick runs the aging step, the arrival scan and the run step, and on a completion
// also the selection scan; the scans visit one table entry per cycle
// one transaction in flight; the result waits in the output register
// rst is synchronous: table empty, clock and counters zero, aging_step 1
`include "preemptive_priority_scheduler_aging_core_assert.svh"
module preemptive_priority_scheduler_aging_core #(
  parameter int MAX_ENTRIES = ppsa_pkg::MAX_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [7:0]  proc_id,
  input  logic signed [15:0] prio_value,
  input  logic [15:0] arrive_at,
  input  logic [15:0] burst_len,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] now_tick,
  output logic        run_valid,
  output logic [7:0]  run_id,
  output logic        idle_flag,
  output logic        preempt_flag,
  output logic        done_valid,
  output logic [7:0]  done_id,
  output logic [15:0] turnaround_ticks,
  output logic [15:0] wait_ticks,
  output logic [15:0] response_ticks,
  output logic [15:0] busy_ticks,
  output logic        all_done,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data
);
  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_ENTRIES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_AGE  = 3'd1;
  localparam logic [2:0] S_ARR  = 3'd2;
  localparam logic [2:0] S_RUN  = 3'd3;
  localparam logic [2:0] S_SEL  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]    state;
  logic [7:0]    step;
  logic [CW-1:0] count;
  logic [CW-1:0] finished;
  logic [CW-1:0] scan;
  logic [IW-1:0] cur;
  logic          cur_valid;
  logic [15:0]   now;
  logic [15:0]   busy;
  logic [16:0]   fin;
  logic          arrived, ran, preempt, done;
  logic [7:0]    rid, did;
  logic [15:0]   turn, wt, resp;

  ppsa_pkg::entry_t    ent [MAX_ENTRIES];
  ppsa_pkg::cell_ctl_t ctl [MAX_ENTRIES];
  ppsa_pkg::entry_t    se, ce;
  logic [IW-1:0]       sidx;
  logic                ld_go, start_go, dec_go;
  logic [IW-1:0]       start_idx;
  logic [15:0]         start_resp;
  logic [16:0]         turn_raw;
  logic [15:0]         turn_sat;
  logic                accept;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE) || out_valid;
  assign sidx = scan[IW-1:0];
  assign se = ent[sidx];
  assign ce = ent[cur];
  assign ld_go = accept && operation == ppsa_pkg::OP_LOAD && count < MAXC;
  assign dec_go = state == S_RUN && cur_valid;
  assign turn_raw = (fin >= {1'b0, ce.arr}) ? fin - {1'b0, ce.arr} : 17'd0;
  assign turn_sat = turn_raw[16] ? 16'hFFFF : turn_raw[15:0];

  always_comb begin
    start_go = 1'b0;
    start_idx = sidx;
    start_resp = 16'd0;
    if (state == S_ARR && scan != count && se.arr == now && se.rem != 16'd0 &&
        (!cur_valid || $signed(se.prio) < $signed(ce.prio))) begin
      start_go = 1'b1;
      start_resp = now - se.arr;
    end else if (state == S_FIN && cur_valid) begin
      start_go = 1'b1;
      start_idx = cur;
      start_resp = fin[15:0] - ce.arr;
    end
  end

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    always_comb begin
      ctl[g].load = ld_go && count[IW-1:0] == IW'(g);
      ctl[g].age = state == S_AGE && CW'(g) < count;
      ctl[g].start = start_go && start_idx == IW'(g);
      ctl[g].dec = dec_go && cur == IW'(g);
    end
    ppsa_cell u_cell (
      .clk(clk), .rst(rst), .ctl(ctl[g]),
      .ld_id(proc_id), .ld_prio(prio_value), .ld_arr(arrive_at), .ld_burst(burst_len),
      .now(now), .step(step), .start_resp(start_resp), .ent(ent[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= ppsa_pkg::AGING_RESET;
      count <= '0;
      finished <= '0;
      cur <= '0;
      cur_valid <= 1'b0;
      now <= 16'd0;
      busy <= 16'd0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) step <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (ld_go) count <= count + CW'(1);
          if (accept && operation == ppsa_pkg::OP_TICK) begin
            state <= S_AGE;
            arrived <= 1'b0;
            ran <= 1'b0;
            preempt <= 1'b0;
            done <= 1'b0;
            rid <= 8'd0;
            did <= 8'd0;
            turn <= 16'd0;
            wt <= 16'd0;
            resp <= 16'd0;
            fin <= {1'b0, now} + 17'd1;
          end
        end
        S_AGE: begin
          scan <= '0;
          state <= S_ARR;
        end
        S_ARR: begin
          if (scan == count) begin
            state <= S_RUN;
          end else begin
            if (se.arr == now && se.rem != 16'd0) arrived <= 1'b1;
            if (start_go) begin
              if (cur_valid) preempt <= 1'b1;
              cur <= sidx;
              cur_valid <= 1'b1;
            end
            scan <= scan + CW'(1);
          end
        end
        S_RUN: begin
          state <= S_OUT;
          scan <= '0;
          if (cur_valid) begin
            ran <= 1'b1;
            rid <= ce.id;
            busy <= busy + 16'd1;
            if (ce.rem == 16'd1) begin
              done <= 1'b1;
              finished <= finished + CW'(1);
              did <= ce.id;
              turn <= turn_sat;
              wt <= (turn_sat >= ce.burst) ? turn_sat - ce.burst : 16'd0;
              resp <= ce.resp;
              cur_valid <= 1'b0;
              state <= S_SEL;
            end
          end
        end
        S_SEL: begin
          if (scan == count) begin
            state <= S_FIN;
          end else begin
            if (se.rem != 16'd0 && {1'b0, se.arr} <= fin &&
                (!cur_valid || $signed(se.prio) < $signed(ce.prio))) begin
              cur <= sidx;
              cur_valid <= 1'b1;
            end
            scan <= scan + CW'(1);
          end
        end
        S_FIN: begin
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          now_tick <= now;
          run_valid <= ran;
          run_id <= rid;
          idle_flag <= !ran && !arrived;
          preempt_flag <= preempt;
          done_valid <= done;
          done_id <= did;
          turnaround_ticks <= turn;
          wait_ticks <= wt;
          response_ticks <= resp;
          busy_ticks <= busy;
          all_done <= finished == count;
          now <= now + 16'd1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PPSA_ASSERT_NOW(a_fin_le_count, 1'b1, finished <= count, "finished exceeds loaded count")
  `PPSA_ASSERT_NOW(a_cur_in_table, cur_valid, CW'(cur) < count, "current entry out of table")
  `PPSA_ASSERT_NEXT(a_tick_starts, accept && operation == ppsa_pkg::OP_TICK, state == S_AGE,
                    "tick did not start aging")
  `PPSA_ASSERT_NOW(a_done_ran, out_valid && done_valid, run_valid, "completion without run")
endmodule
